FILE: rtl/core/base64_stream_decoder_macros.svh
// Assertion macros shared by the decoder checkers.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/b64d_pkg.sv
// Shared types, constants and the character map of the base64 decoder.
package b64d_pkg;

  // Status codes carried on the end-of-string beat.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_LENGTH  = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  // Offsets that move lower case and digits into their sextet range.
  localparam logic [7:0] LOWER_OFFSET = 8'd26;
  localparam logic [7:0] DIGIT_OFFSET = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // Group queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One input beat.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic [1:0] status;
  } out_beat_t;

  // One group of up to three result beats, as the front hands it on.
  typedef struct packed {
    logic [2:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]      count;   // number of beats, 1 to 3
    logic            has;     // beats carry bytes
    logic            eos;     // last beat closes the string
    logic [1:0]      status;  // status on the closing beat
  } group_t;

  // Sextet lookup result.
  typedef struct packed {
    logic       invalid;
    logic [5:0] sextet;
  } sextet_t;

  // Map one character of the alphabet to its sextet.
  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t r;
    r.invalid = 1'b0;
    r.sextet  = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.sextet = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.sextet = 6'(c - CHAR_LOWER_A + LOWER_OFFSET);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r.sextet = 6'(c - CHAR_DIGIT_0 + DIGIT_OFFSET);
    end else if (c == CHAR_PLUS) begin
      r.sextet = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.sextet = SEXTET_SLASH;
    end else begin
      r.invalid = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/b64d_front.sv
// Front end: accepts characters, tracks group state and forms output groups.
module b64d_front import b64d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_beat_t item,
  output logic     grp_valid,
  output group_t   grp
);

  logic [17:0] sextet_buffer, sextet_buffer_next;
  logic [1:0]  group_position, group_position_next;
  logic [1:0]  length_mod_four, length_mod_four_next;
  logic        padding_seen, padding_seen_next;
  logic        aborted, aborted_next;

  sextet_t     map;
  logic        full_group;
  logic        abort_hit;
  logic [23:0] word;
  logic [1:0]  end_status;

  assign map  = map_char(item.char_code);
  assign word = {sextet_buffer, map.sextet};

  // Decode one character and decide what group it releases
  always_comb begin
    sextet_buffer_next   = sextet_buffer;
    group_position_next  = group_position;
    length_mod_four_next = length_mod_four + 2'd1;
    padding_seen_next    = padding_seen;
    aborted_next         = aborted;
    full_group           = 1'b0;
    abort_hit            = 1'b0;
    grp_valid            = 1'b0;
    grp                  = '0;
    end_status           = STATUS_OK;

    if (aborted) begin
      // swallow the rest of the string
      if (item.last_char) begin
        sextet_buffer_next   = '0;
        group_position_next  = '0;
        length_mod_four_next = '0;
        padding_seen_next    = 1'b0;
        aborted_next         = 1'b0;
      end
    end else begin
      if (!padding_seen) begin
        if (item.char_code == CHAR_PAD) begin
          padding_seen_next = 1'b1;
        end else if (map.invalid) begin
          abort_hit      = 1'b1;
          grp_valid      = 1'b1;
          grp.count      = 2'd1;
          grp.has        = 1'b0;
          grp.eos        = 1'b1;
          grp.status     = STATUS_INVALID;
          if (item.last_char) begin
            sextet_buffer_next   = '0;
            group_position_next  = '0;
            length_mod_four_next = '0;
            padding_seen_next    = 1'b0;
          end else begin
            aborted_next = 1'b1;
          end
        end else if (group_position == 2'd3) begin
          full_group          = 1'b1;
          grp.bytes[0]        = word[23:16];
          grp.bytes[1]        = word[15:8];
          grp.bytes[2]        = word[7:0];
          sextet_buffer_next  = '0;
          group_position_next = '0;
        end else begin
          sextet_buffer_next  = {sextet_buffer[11:0], map.sextet};
          group_position_next = group_position + 2'd1;
        end
      end

      if (!abort_hit) begin
        if (item.last_char) begin
          // close the string: flush a partial group and attach the status
          end_status = (length_mod_four_next != 2'd0) ? STATUS_LENGTH : STATUS_OK;
          grp_valid  = 1'b1;
          grp.eos    = 1'b1;
          grp.status = end_status;
          if (full_group) begin
            grp.count = 2'd3;
            grp.has   = 1'b1;
          end else if (group_position_next == 2'd2) begin
            grp.bytes[0] = sextet_buffer_next[11:4];
            grp.count    = 2'd1;
            grp.has      = 1'b1;
          end else if (group_position_next == 2'd3) begin
            grp.bytes[0] = sextet_buffer_next[17:10];
            grp.bytes[1] = sextet_buffer_next[9:2];
            grp.count    = 2'd2;
            grp.has      = 1'b1;
          end else begin
            grp.count = 2'd1;
            grp.has   = 1'b0;
          end
          sextet_buffer_next   = '0;
          group_position_next  = '0;
          length_mod_four_next = '0;
          padding_seen_next    = 1'b0;
        end else if (full_group) begin
          grp_valid  = 1'b1;
          grp.count  = 2'd3;
          grp.has    = 1'b1;
          grp.eos    = 1'b0;
          grp.status = STATUS_OK;
        end
      end
    end

    // only an accepted beat releases a group
    grp_valid = grp_valid & accept;
  end

  // Advance string state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buffer   <= '0;
      group_position  <= '0;
      length_mod_four <= '0;
      padding_seen    <= 1'b0;
      aborted         <= 1'b0;
    end else if (accept) begin
      sextet_buffer   <= sextet_buffer_next;
      group_position  <= group_position_next;
      length_mod_four <= length_mod_four_next;
      padding_seen    <= padding_seen_next;
      aborted         <= aborted_next;
    end
  end

endmodule

FILE: rtl/core/b64d_fifo.sv
// Short queue of decoded groups between the front and back ends.
module b64d_fifo import b64d_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  group_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output group_t rd_data,
  output logic   empty
);

  group_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr, do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Store incoming groups
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/b64d_back.sv
// Back end: splits queued groups into result beats behind an output register.
module b64d_back import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  group_t    head,
  input  logic      head_empty,
  output logic      head_pop,
  output logic      empty,
  input  logic      pop,
  output out_beat_t result
);

  logic [1:0] beat_idx, beat_idx_next;
  logic       out_valid, out_valid_next;
  out_beat_t  out_beat, out_beat_next;
  logic       load;
  logic       final_beat;
  logic [7:0] pick;

  assign load       = !head_empty && (!out_valid || pop);
  assign final_beat = (beat_idx == head.count - 2'd1);
  assign empty      = !out_valid;
  assign result     = out_beat;

  // Select the byte for the current beat
  always_comb begin
    unique case (beat_idx)
      2'd0:    pick = head.bytes[0];
      2'd1:    pick = head.bytes[1];
      default: pick = head.bytes[2];
    endcase
  end

  // Form the next beat and step through the group
  always_comb begin
    out_beat_next               = out_beat;
    beat_idx_next               = beat_idx;
    head_pop                    = 1'b0;
    out_valid_next              = out_valid && !pop;
    if (load) begin
      out_valid_next              = 1'b1;
      out_beat_next.out_byte      = head.has ? pick : 8'd0;
      out_beat_next.has_byte      = head.has;
      out_beat_next.end_of_string = head.eos && final_beat;
      out_beat_next.status        = (head.eos && final_beat) ? head.status : STATUS_OK;
      if (final_beat) begin
        head_pop      = 1'b1;
        beat_idx_next = '0;
      end else begin
        beat_idx_next = beat_idx + 2'd1;
      end
    end
  end

  // Hold the beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat_idx  <= '0;
    end else begin
      out_valid <= out_valid_next;
      beat_idx  <= beat_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    out_beat <= out_beat_next;
  end

endmodule

FILE: rtl/core/base64_stream_decoder.sv
// Top level of the streaming base64 decoder.
// Takes one base64 character per clock while full is low and gives at most one
// result beat per clock from a registered output. A character reaches the
// queue in the cycle it is accepted, then passes through the output register
// to the result ports. The back end drains one beat per cycle while pop is
// high, so a complete group of four characters gives three result beats; the
// four-group queue between the ends absorbs bursts, and full rises only when
// all four slots hold groups because the consumer has not kept up. Strings
// close with a beat marked end_of_string carrying ok, invalid character or
// bad length; an invalid character before padding ends it at once, swallowing the rest.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_beat_t  item,
  output logic      empty,
  input  logic      pop,
  output out_beat_t result
);

  logic   accept;
  logic   grp_valid;
  group_t grp;
  group_t head;
  logic   head_empty;
  logic   head_pop;

  assign accept = push && !full;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  b64d_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_valid),
    .wr_data (grp),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

FILE: rtl/core/b64d_checker.sv
// Port-level checks on the base64 decoder, bound to the top level.
`include "base64_stream_decoder_macros.svh"

module b64d_checker import b64d_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_beat_t  item,
  input logic      empty,
  input logic      pop,
  input out_beat_t result
);

  // hold a waiting beat until it is taken
  `B64D_ASSERT_NEXT(a_hold_beat, !empty && !pop, !empty && $stable(result), "result beat changed while waiting")

  // a beat without a byte must close a string
  `B64D_ASSERT_NOW(a_empty_beat_ends, !empty && !result.has_byte, result.end_of_string, "byteless beat without end mark")

  // status only rides on a closing beat
  `B64D_ASSERT_NOW(a_status_on_end, !empty && !result.end_of_string, result.status == STATUS_OK, "status set on a non-closing beat")

  // an abort beat never carries a byte
  `B64D_ASSERT_NOW(a_abort_no_byte, !empty && result.status == STATUS_INVALID, !result.has_byte && result.out_byte == 8'd0, "abort beat carries a byte")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

FILE: sim/b64d_tb_pkg.sv
// Scoreboard class that predicts and checks the decoder's result beats.
package b64d_tb_pkg;
  import b64d_pkg::*;

  // Sextet of one character; bit 6 flags a character outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] code;
    code = 7'h40;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      code = {1'b0, 6'(c - CHAR_UPPER_A)};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      code = {1'b0, 6'(c - CHAR_LOWER_A + LOWER_OFFSET)};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      code = {1'b0, 6'(c - CHAR_DIGIT_0 + DIGIT_OFFSET)};
    end else if (c == CHAR_PLUS) begin
      code = {1'b0, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      code = {1'b0, SEXTET_SLASH};
    end
    return code;
  endfunction

  class b64_decode_predictor;
    out_beat_t   due_beats[$];
    logic [17:0] sextets;
    logic [1:0]  fill;
    logic [1:0]  count_mod4;
    bit          pad_seen;
    bit          swallowing;
    int          mismatches;
    int          chars_seen;
    int          beats_checked;
    int          closed_by_status[3];

    function new();
      clear_string();
    endfunction

    function void clear_string();
      sextets    = '0;
      fill       = '0;
      count_mod4 = '0;
      pad_seen   = 1'b0;
      swallowing = 1'b0;
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    // Queue one expected beat.
    function void owe(logic [7:0] b, logic has, logic eos, logic [1:0] st);
      out_beat_t r;
      r.out_byte      = b;
      r.has_byte      = has;
      r.end_of_string = eos;
      r.status        = st;
      due_beats.push_back(r);
      if (eos) closed_by_status[st]++;
    endfunction

    // Advance the decoder state by one accepted character.
    function void note_char(in_beat_t b);
      logic [6:0]  code;
      logic [23:0] group;
      logic [7:0]  bytes[3];
      int          nb;
      logic [1:0]  st;
      nb = 0;
      chars_seen++;
      count_mod4 = count_mod4 + 2'd1;
      // Swallow the rest of an aborted string.
      if (swallowing) begin
        if (b.last_char) clear_string();
        return;
      end
      if (!pad_seen) begin
        if (b.char_code == CHAR_PAD) begin
          pad_seen = 1'b1;
        end else begin
          code = sextet_of(b.char_code);
          if (code[6]) begin
            owe(8'h00, 1'b0, 1'b1, STATUS_INVALID);
            if (b.last_char) clear_string();
            else swallowing = 1'b1;
            return;
          end
          if (fill == 2'd3) begin
            group    = {sextets, code[5:0]};
            bytes[0] = group[23:16];
            bytes[1] = group[15:8];
            bytes[2] = group[7:0];
            nb       = 3;
            sextets  = '0;
            fill     = '0;
          end else begin
            sextets = {sextets[11:0], code[5:0]};
            fill    = fill + 2'd1;
          end
        end
      end
      if (!b.last_char) begin
        for (int i = 0; i < nb; i++) owe(bytes[i], 1'b1, 1'b0, STATUS_OK);
        return;
      end
      // Flush a partial group and close the string.
      if (fill == 2'd2) begin
        bytes[nb] = sextets[11:4];
        nb = nb + 1;
      end else if (fill == 2'd3) begin
        bytes[nb]     = sextets[17:10];
        bytes[nb + 1] = sextets[9:2];
        nb = nb + 2;
      end
      st = (count_mod4 != 2'd0) ? STATUS_LENGTH : STATUS_OK;
      if (nb == 0) begin
        owe(8'h00, 1'b0, 1'b1, st);
      end else begin
        for (int i = 0; i < nb; i++) begin
          owe(bytes[i], 1'b1, i == nb - 1, (i == nb - 1) ? st : STATUS_OK);
        end
      end
      clear_string();
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_beat(out_beat_t got);
      out_beat_t want;
      beats_checked++;
      if (due_beats.size() == 0) begin
        $error("unexpected beat: out_byte %0h has_byte %0b end_of_string %0b status %0d",
               got.out_byte, got.has_byte, got.end_of_string, got.status);
        mismatches++;
        return;
      end
      want = due_beats.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.has_byte !== want.has_byte) begin
        $error("has_byte: expected %0b, actual %0b", want.has_byte, got.has_byte);
        mismatches++;
      end
      if (got.end_of_string !== want.end_of_string) begin
        $error("end_of_string: expected %0b, actual %0b",
               want.end_of_string, got.end_of_string);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_base64_stream_decoder.sv
// Testbench top for the streaming base64 decoder.
module tb_base64_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;
  import b64d_tb_pkg::*;

  localparam int RANDOM_CHARS   = 270;
  localparam int QUIET_LIMIT    = 4000;
  localparam int LINGER_CYCLES  = 16;

  typedef logic [7:0] char_q_t[$];

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_beat_t  item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_beat_t result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int strings_sent   = 0;

  b64_decode_predictor predictor = new();

  base64_stream_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result side at random.
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Note accepted characters, check accepted beats, watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) predictor.note_char(item);
      if (pop && !empty) predictor.check_beat(result);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one character and hold it until the decoder takes it.
  task automatic send_char(input in_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_chars(input char_q_t s);
    in_beat_t b;
    for (int i = 0; i < s.size(); i++) begin
      b.char_code = s[i];
      b.last_char = (i == s.size() - 1);
      send_char(b);
    end
    strings_sent++;
  endtask

  task automatic send_text(input string t);
    char_q_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_chars(s);
  endtask

  function automatic logic [7:0] char_of_sextet(input int v);
    if (v < 26) return CHAR_UPPER_A + 8'(v);
    if (v < 52) return CHAR_LOWER_A + 8'(v - 26);
    if (v < 62) return CHAR_DIGIT_0 + 8'(v - 52);
    if (v == 62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  // Build one random string: mostly well-formed text, some broken, some noise.
  task automatic make_string(output char_q_t s);
    int kind, n, pad;
    s = {};
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      n = 4 * $urandom_range(1, 3);
      for (int i = 0; i < n; i++) s.push_back(char_of_sextet($urandom_range(0, 63)));
      pad = $urandom_range(0, 2);
      for (int i = 0; i < pad; i++) s[n - 1 - i] = CHAR_PAD;
    end else if (kind < 80) begin
      n = $urandom_range(1, 11);
      for (int i = 0; i < n; i++) s.push_back(char_of_sextet($urandom_range(0, 63)));
      if ($urandom_range(0, 1)) s[$urandom_range(0, n - 1)] = CHAR_PAD;
    end else if (kind < 90) begin
      n = 4 * $urandom_range(1, 2);
      for (int i = 0; i < n; i++) s.push_back(char_of_sextet($urandom_range(0, 63)));
      s[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) s.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Hold the sender until every expected beat is back, then linger.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (predictor.pending() != 0);
    repeat (LINGER_CYCLES) @(posedge clk);
  endtask

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    int phase_chars;
    char_q_t s;
    idle_by_phase  = '{0, 84, 0, 25};
    stall_by_phase = '{0, 0, 84, 25};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: alphabet edges, padding, trailing text, bad lengths, aborts.
    send_text("Zz9+//+/");
    send_text("Aa0=");
    send_text("TQ==Yw");
    send_text("T");
    send_char('{char_code: 8'h00, last_char: 1'b1});
    strings_sent++;
    send_char('{char_code: 8'h51, last_char: 1'b0});
    send_char('{char_code: 8'hFF, last_char: 1'b0});
    send_text("Bx");
    drain();

    // Random strings under each idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      phase_chars = 0;
      while (phase_chars < RANDOM_CHARS / 4) begin
        make_string(s);
        send_chars(s);
        phase_chars += s.size();
      end
      drain();
    end

    if (predictor.pending() != 0) begin
      $error("%0d expected beats never arrived", predictor.pending());
      predictor.mismatches++;
    end
    $display("Decoded %0d strings, %0d characters, %0d result beats over four idling phases.",
             strings_sent, predictor.chars_seen, predictor.beats_checked);
    $display("Strings closed ok %0d, invalid character %0d, bad length %0d.",
             predictor.closed_by_status[STATUS_OK], predictor.closed_by_status[STATUS_INVALID],
             predictor.closed_by_status[STATUS_LENGTH]);
    if (predictor.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
